### rtl/core/rhtbl_pkg.sv
// ----------------------------------------------------------------------------
// rhtbl_pkg
// Shared types and constants of the reference-counted handle table.
// ----------------------------------------------------------------------------
package rhtbl_pkg;

  localparam int SLOTS      = 256;
  localparam int IDX_BITS   = $clog2(SLOTS);
  localparam int FILL_BITS  = $clog2(SLOTS + 1);
  localparam int VER_BITS   = 8;
  localparam int COUNT_BITS = 16;
  localparam int VALUE_BITS = 64;
  localparam int NAME_BITS  = 128;
  localparam int HALF_BITS  = 64;
  localparam int FUNC_BITS  = 3;
  localparam int STAT_BITS  = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // request function codes
  typedef enum logic [FUNC_BITS-1:0] {
    FN_ADD      = 3'd0,
    FN_RETAIN   = 3'd1,
    FN_RELEASE  = 3'd2,
    FN_GET      = 3'd3,
    FN_FIND     = 3'd4,
    FN_GET_NAME = 3'd5,
    FN_CLEAR    = 3'd6
  } func_t;

  // result status codes
  typedef enum logic [STAT_BITS-1:0] {
    ST_DONE    = 3'd0,
    ST_STALE   = 3'd1,
    ST_NULL    = 3'd2,
    ST_PRESENT = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // one slot entry as stored in the slot memory
  typedef struct packed {
    logic [VER_BITS-1:0]   ver;
    logic [COUNT_BITS-1:0] count;
    logic [NAME_BITS-1:0]  name;
    logic [VALUE_BITS-1:0] value;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_ALLOC,
    S_FIFO_WAIT,
    S_REUSE,
    S_HND_EXEC,
    S_RESP
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_ADD_HIT,
    OP_FIND_HIT,
    OP_FIFO_RD,
    OP_REUSE_RD,
    OP_REUSE_WR,
    OP_NEW_WR,
    OP_FULL,
    OP_NULL,
    OP_STALE,
    OP_HND_RD,
    OP_HND_EXEC
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   clear;
    logic   resp_load;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  null_name;
    logic  idx_ok;
    logic  used_zero;
    logic  scan_hit;
    logic  scan_last;
    logic  free_avail;
    logic  out_free;
  } dp_stat_t;

endpackage

### rtl/core/rhtbl_in_if.sv
// ----------------------------------------------------------------------------
// rhtbl_in_if
// Request channel of the handle table.
// ----------------------------------------------------------------------------
interface rhtbl_in_if;
  import rhtbl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FUNC_BITS-1:0]  func;
  logic [HALF_BITS-1:0]  name_high;
  logic [HALF_BITS-1:0]  name_low;
  logic [IDX_BITS-1:0]   slot_index;
  logic [VER_BITS-1:0]   slot_version;
  logic [HALF_BITS-1:0]  value_data;

  modport source (output valid, func, name_high, name_low, slot_index, slot_version,
                  value_data, input ready);
  modport sink   (input valid, func, name_high, name_low, slot_index, slot_version,
                  value_data, output ready);
endinterface

### rtl/core/rhtbl_out_if.sv
// ----------------------------------------------------------------------------
// rhtbl_out_if
// Result channel of the handle table.
// ----------------------------------------------------------------------------
interface rhtbl_out_if;
  import rhtbl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STAT_BITS-1:0]  status;
  logic [IDX_BITS-1:0]   out_index;
  logic [VER_BITS-1:0]   out_version;
  logic [HALF_BITS-1:0]  out_value;
  logic [HALF_BITS-1:0]  out_name_high;
  logic [HALF_BITS-1:0]  out_name_low;
  logic [FILL_BITS-1:0]  live_items;

  modport source (output valid, status, out_index, out_version, out_value,
                  out_name_high, out_name_low, live_items, input ready);
  modport sink   (input valid, status, out_index, out_version, out_value,
                  out_name_high, out_name_low, live_items, output ready);
endinterface

### rtl/core/refcounted_handle_table.sv
// ----------------------------------------------------------------------------
// refcounted_handle_table
// Generational slot table of named, reference-counted values.
// ----------------------------------------------------------------------------
// Retain, release, get, get name read the slot, execute, then load the result; past the used
//   width the stale result is loaded without a slot read, as for clear, null add and null find.
// Add and find scan the slot memory one entry at a time, each read (registered read) then
//   compared; an add that misses reuses a freed slot, else opens a new one if room is left.
// One request at a time: the next one is taken the cycle after the result is loaded;
//   a waiting result does not block taking it. Synchronous active-low reset empties the table.
module refcounted_handle_table (
  input logic        clk,
  input logic        rst_n,
  rhtbl_in_if.sink   in_req,
  rhtbl_out_if.source out_rsp
);
  import rhtbl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  rhtbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath and memories
  rhtbl_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_req.func),
    .in_name_high    (in_req.name_high),
    .in_name_low     (in_req.name_low),
    .in_slot_index   (in_req.slot_index),
    .in_slot_version (in_req.slot_version),
    .in_value_data   (in_req.value_data),
    .out_valid       (out_rsp.valid),
    .out_ready       (out_rsp.ready),
    .out_status      (out_rsp.status),
    .out_index       (out_rsp.out_index),
    .out_version     (out_rsp.out_version),
    .out_value       (out_rsp.out_value),
    .out_name_high   (out_rsp.out_name_high),
    .out_name_low    (out_rsp.out_name_low),
    .out_live_items  (out_rsp.live_items)
  );

  // result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp_load |-> stat.out_free)
    else $error("result loaded over a pending result");

  // an accepted request makes the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request taken while busy");

  // live item count never exceeds the table size
  a_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> (out_rsp.live_items <= FILL_BITS'(SLOTS)))
    else $error("live item count out of range");

endmodule

### rtl/core/rhtbl_ram.sv
// ----------------------------------------------------------------------------
// rhtbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rhtbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/rhtbl_ctrl.sv
// ----------------------------------------------------------------------------
// rhtbl_ctrl
// Request sequencer: decodes the request and steps the datapath.
// ----------------------------------------------------------------------------
module rhtbl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rhtbl_pkg::dp_stat_t stat,
  output rhtbl_pkg::dp_cmd_t  cmd
);
  import rhtbl_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.func) inside
          FN_ADD: begin
            if (stat.null_name) state_nxt = S_RESP;
            else if (stat.used_zero) state_nxt = S_ALLOC;
            else state_nxt = S_SCAN_RD;
          end
          FN_FIND: begin
            if (stat.null_name || stat.used_zero) state_nxt = S_RESP;
            else state_nxt = S_SCAN_RD;
          end
          FN_RETAIN, FN_RELEASE, FN_GET, FN_GET_NAME: begin
            state_nxt = stat.idx_ok ? S_HND_EXEC : S_RESP;
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (stat.scan_hit) state_nxt = S_RESP;
        else if (stat.scan_last) state_nxt = (stat.func == FN_ADD) ? S_ALLOC : S_RESP;
        else state_nxt = S_SCAN_RD;
      end
      S_ALLOC:     state_nxt = stat.free_avail ? S_FIFO_WAIT : S_RESP;
      S_FIFO_WAIT: state_nxt = S_REUSE;
      S_REUSE:     state_nxt = S_RESP;
      S_HND_EXEC:  state_nxt = S_RESP;
      S_RESP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '{op: OP_NONE, clear: 1'b0, resp_load: 1'b0};
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LATCH;
      end
      S_DECODE: begin
        unique case (stat.func) inside
          FN_ADD: begin
            if (stat.null_name) cmd.op = OP_NULL;
            else if (!stat.used_zero) cmd.op = OP_SCAN_INIT;
          end
          FN_FIND: begin
            if (stat.null_name || stat.used_zero) cmd.op = OP_STALE;
            else cmd.op = OP_SCAN_INIT;
          end
          FN_RETAIN, FN_RELEASE, FN_GET, FN_GET_NAME: begin
            cmd.op = stat.idx_ok ? OP_HND_RD : OP_STALE;
          end
          FN_CLEAR: cmd.clear = 1'b1;
          default:  cmd.op = OP_STALE;
        endcase
      end
      S_SCAN_RD: cmd.op = OP_SCAN_RD;
      S_SCAN_CMP: begin
        if (stat.scan_hit) cmd.op = (stat.func == FN_ADD) ? OP_ADD_HIT : OP_FIND_HIT;
        else if (stat.scan_last) cmd.op = (stat.func == FN_ADD) ? OP_NONE : OP_STALE;
        else cmd.op = OP_SCAN_NEXT;
      end
      S_ALLOC: begin
        // reuse a freed slot first, else open a new one
        if (stat.free_avail) cmd.op = OP_FIFO_RD;
        else cmd.op = OP_NEW_WR;
      end
      S_FIFO_WAIT: cmd.op = OP_REUSE_RD;
      S_REUSE:     cmd.op = OP_REUSE_WR;
      S_HND_EXEC:  cmd.op = OP_HND_EXEC;
      S_RESP:      cmd.resp_load = stat.out_free;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

### rtl/core/rhtbl_dpath.sv
// ----------------------------------------------------------------------------
// rhtbl_dpath
// Datapath: request registers, slot and free-list memories, table counters
// and the result register.
// ----------------------------------------------------------------------------
module rhtbl_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rhtbl_pkg::dp_cmd_t                  cmd,
  output rhtbl_pkg::dp_stat_t                 stat,
  input  logic [rhtbl_pkg::FUNC_BITS-1:0]     in_func,
  input  logic [rhtbl_pkg::HALF_BITS-1:0]     in_name_high,
  input  logic [rhtbl_pkg::HALF_BITS-1:0]     in_name_low,
  input  logic [rhtbl_pkg::IDX_BITS-1:0]      in_slot_index,
  input  logic [rhtbl_pkg::VER_BITS-1:0]      in_slot_version,
  input  logic [rhtbl_pkg::HALF_BITS-1:0]     in_value_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rhtbl_pkg::STAT_BITS-1:0]     out_status,
  output logic [rhtbl_pkg::IDX_BITS-1:0]      out_index,
  output logic [rhtbl_pkg::VER_BITS-1:0]      out_version,
  output logic [rhtbl_pkg::HALF_BITS-1:0]     out_value,
  output logic [rhtbl_pkg::HALF_BITS-1:0]     out_name_high,
  output logic [rhtbl_pkg::HALF_BITS-1:0]     out_name_low,
  output logic [rhtbl_pkg::FILL_BITS-1:0]     out_live_items
);
  import rhtbl_pkg::*;

  // request registers
  func_t                 func_r, func_nxt;
  logic [NAME_BITS-1:0]  name_r, name_nxt;
  logic [IDX_BITS-1:0]   idx_r, idx_nxt;
  logic [VER_BITS-1:0]   ver_r, ver_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [IDX_BITS-1:0]   k_r, k_nxt;
  logic [IDX_BITS-1:0]   s_r, s_nxt;

  // table control state
  logic [FILL_BITS-1:0]  used_r, used_nxt;
  logic [IDX_BITS-1:0]   head_r, head_nxt;
  logic [IDX_BITS-1:0]   tail_r, tail_nxt;
  logic [FILL_BITS-1:0]  fcount_r, fcount_nxt;
  logic [FILL_BITS-1:0]  total_r, total_nxt;

  // staged result
  status_t               rs_status_r, rs_status_nxt;
  logic [IDX_BITS-1:0]   rs_idx_r, rs_idx_nxt;
  logic [VER_BITS-1:0]   rs_ver_r, rs_ver_nxt;
  logic [HALF_BITS-1:0]  rs_val_r, rs_val_nxt;
  logic [NAME_BITS-1:0]  rs_name_r, rs_name_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_BITS-1:0]  o_status_r;
  logic [IDX_BITS-1:0]   o_idx_r;
  logic [VER_BITS-1:0]   o_ver_r;
  logic [HALF_BITS-1:0]  o_val_r;
  logic [NAME_BITS-1:0]  o_name_r;
  logic [FILL_BITS-1:0]  o_live_r;

  // memory ports
  logic                  slot_we;
  logic [IDX_BITS-1:0]   slot_waddr;
  slot_t                 slot_wdata;
  logic [IDX_BITS-1:0]   slot_raddr;
  slot_t                 slot_rdata;
  logic                  fifo_we;
  logic [IDX_BITS-1:0]   fifo_rdata;

  logic                  live;
  logic                  cnt_nz;
  logic [COUNT_BITS-1:0] cnt_up;

  rhtbl_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  rhtbl_ram #(.WIDTH(IDX_BITS), .DEPTH(SLOTS)) u_free_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail_r),
    .wdata (idx_r),
    .raddr (head_r),
    .rdata (fifo_rdata)
  );

  // handle and count checks on the slot just read
  assign live   = (slot_rdata.ver == ver_r);
  assign cnt_nz = (slot_rdata.count != '0);
  assign cnt_up = (slot_rdata.count == COUNT_MAX) ? COUNT_MAX
                                                  : slot_rdata.count + 1'b1;

  // status to the controller
  always_comb begin
    stat.func       = func_r;
    stat.null_name  = (name_r == '0);
    stat.idx_ok     = ({1'b0, idx_r} < used_r);
    stat.used_zero  = (used_r == '0);
    stat.scan_hit   = (slot_rdata.name == name_r);
    stat.scan_last  = (FILL_BITS'({1'b0, k_r}) + 1'b1 == used_r);
    stat.free_avail = (fcount_r != '0);
    stat.out_free   = !out_valid_r || out_ready;
  end

  // operation decode
  always_comb begin
    func_nxt      = func_r;
    name_nxt      = name_r;
    idx_nxt       = idx_r;
    ver_nxt       = ver_r;
    val_nxt       = val_r;
    k_nxt         = k_r;
    s_nxt         = s_r;
    used_nxt      = used_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fcount_nxt    = fcount_r;
    total_nxt     = total_r;
    rs_status_nxt = rs_status_r;
    rs_idx_nxt    = rs_idx_r;
    rs_ver_nxt    = rs_ver_r;
    rs_val_nxt    = rs_val_r;
    rs_name_nxt   = rs_name_r;
    slot_we       = 1'b0;
    slot_waddr    = k_r;
    slot_wdata    = slot_rdata;
    slot_raddr    = k_r;
    fifo_we       = 1'b0;

    case (cmd.op)
      OP_LATCH: begin
        func_nxt      = func_t'(in_func);
        name_nxt      = {in_name_high, in_name_low};
        idx_nxt       = in_slot_index;
        ver_nxt       = in_slot_version;
        val_nxt       = in_value_data[VALUE_BITS-1:0];
        rs_status_nxt = ST_STALE;
        rs_idx_nxt    = '0;
        rs_ver_nxt    = '0;
        rs_val_nxt    = '0;
        rs_name_nxt   = '0;
      end
      OP_SCAN_INIT: k_nxt = '0;
      OP_SCAN_RD:   slot_raddr = k_r;
      OP_SCAN_NEXT: k_nxt = k_r + 1'b1;
      OP_ADD_HIT: begin
        slot_we          = 1'b1;
        slot_waddr       = k_r;
        slot_wdata.count = cnt_up;
        rs_status_nxt    = ST_PRESENT;
        rs_idx_nxt       = k_r;
        rs_ver_nxt       = slot_rdata.ver;
      end
      OP_FIND_HIT: begin
        rs_status_nxt = ST_DONE;
        rs_idx_nxt    = k_r;
        rs_ver_nxt    = slot_rdata.ver;
      end
      OP_FIFO_RD: ;
      OP_REUSE_RD: begin
        slot_raddr = fifo_rdata;
        s_nxt      = fifo_rdata;
      end
      OP_REUSE_WR: begin
        // reused slot keeps the version it got when freed
        slot_we       = 1'b1;
        slot_waddr    = s_r;
        slot_wdata    = '{ver: slot_rdata.ver, count: COUNT_BITS'(1), name: name_r,
                          value: val_r};
        head_nxt      = head_r + 1'b1;
        fcount_nxt    = fcount_r - 1'b1;
        total_nxt     = total_r + 1'b1;
        rs_status_nxt = ST_DONE;
        rs_idx_nxt    = s_r;
        rs_ver_nxt    = slot_rdata.ver;
      end
      OP_NEW_WR: begin
        if (used_r < FILL_BITS'(SLOTS)) begin
          slot_we       = 1'b1;
          slot_waddr    = used_r[IDX_BITS-1:0];
          slot_wdata    = '{ver: VER_BITS'(1), count: COUNT_BITS'(1), name: name_r,
                            value: val_r};
          used_nxt      = used_r + 1'b1;
          total_nxt     = total_r + 1'b1;
          rs_status_nxt = ST_DONE;
          rs_idx_nxt    = used_r[IDX_BITS-1:0];
          rs_ver_nxt    = VER_BITS'(1);
        end else begin
          rs_status_nxt = ST_FULL;
        end
      end
      OP_FULL:  rs_status_nxt = ST_FULL;
      OP_NULL:  rs_status_nxt = ST_NULL;
      OP_STALE: rs_status_nxt = ST_STALE;
      OP_HND_RD: slot_raddr = idx_r;
      OP_HND_EXEC: begin
        slot_waddr = idx_r;
        case (func_r)
          FN_RETAIN: begin
            if (live && cnt_nz) begin
              slot_we          = 1'b1;
              slot_wdata.count = cnt_up;
              rs_status_nxt    = ST_DONE;
            end
          end
          FN_RELEASE: begin
            if (live && cnt_nz) begin
              slot_we       = 1'b1;
              rs_status_nxt = ST_DONE;
              if (slot_rdata.count == COUNT_BITS'(1)) begin
                // final release frees the slot
                slot_wdata = '{ver: slot_rdata.ver + 1'b1, count: '0, name: '0,
                               value: '0};
                fifo_we    = 1'b1;
                tail_nxt   = tail_r + 1'b1;
                fcount_nxt = fcount_r + 1'b1;
                total_nxt  = total_r - 1'b1;
                rs_val_nxt = HALF_BITS'(slot_rdata.value);
              end else begin
                slot_wdata.count = slot_rdata.count - 1'b1;
              end
            end
          end
          FN_GET: begin
            if (live) begin
              rs_val_nxt    = HALF_BITS'(slot_rdata.value);
              rs_status_nxt = ST_DONE;
            end
          end
          FN_GET_NAME: begin
            if (live) begin
              rs_name_nxt   = slot_rdata.name;
              rs_status_nxt = ST_DONE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // clear empties the table; entries beyond the used width are never read
    if (cmd.clear) begin
      used_nxt      = '0;
      head_nxt      = '0;
      tail_nxt      = '0;
      fcount_nxt    = '0;
      total_nxt     = '0;
      rs_status_nxt = ST_DONE;
    end
  end

  // output valid
  always_comb begin
    if (cmd.resp_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fcount_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fcount_r    <= fcount_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    name_r      <= name_nxt;
    idx_r       <= idx_nxt;
    ver_r       <= ver_nxt;
    val_r       <= val_nxt;
    k_r         <= k_nxt;
    s_r         <= s_nxt;
    rs_status_r <= rs_status_nxt;
    rs_idx_r    <= rs_idx_nxt;
    rs_ver_r    <= rs_ver_nxt;
    rs_val_r    <= rs_val_nxt;
    rs_name_r   <= rs_name_nxt;
    if (cmd.resp_load) begin
      o_status_r <= rs_status_r;
      o_idx_r    <= rs_idx_r;
      o_ver_r    <= rs_ver_r;
      o_val_r    <= rs_val_r;
      o_name_r   <= rs_name_r;
      o_live_r   <= total_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = o_status_r;
  assign out_index      = o_idx_r;
  assign out_version    = o_ver_r;
  assign out_value      = o_val_r;
  assign out_name_high  = o_name_r[NAME_BITS-1:HALF_BITS];
  assign out_name_low   = o_name_r[HALF_BITS-1:0];
  assign out_live_items = o_live_r;

endmodule
